[design/stream_find_replace_macros.svh]
// Assertion macros shared by the stream_find_replace modules.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef STREAM_FIND_REPLACE_MACROS_SVH
`define STREAM_FIND_REPLACE_MACROS_SVH

// same-cycle implication
`define SFR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/sfr_pkg.sv]
// Shared types and constants for stream_find_replace.
// No dependencies.
package sfr_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_W  = 64;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_PAT_BYTES = 2'd0;
    localparam logic [IDX_W-1:0] REG_PAT_LEN   = 2'd1;
    localparam logic [IDX_W-1:0] REG_REP_BYTES = 2'd2;
    localparam logic [IDX_W-1:0] REG_REP_LEN   = 2'd3;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_BUF,
        EMIT_REP,
        EMIT_MARK
    } t_emit;

    typedef struct packed {
        logic  load;
        t_emit emit_sel;
        logic  last;
        logic  shift;
        logic  cnt_clr;
        logic  rep_inc;
    } t_cmd;

    typedef struct packed {
        logic match;
        logic full;
        logic cnt_zero;
        logic cnt_one;
        logic rep_last;
        logic rlen_zero;
        logic out_free;
        logic item_end;
        logic emitted;
    } t_stat;

endpackage

[design/stream_find_replace.sv]
// Streaming find-and-replace-all: top level, joins controller and datapath.
// Depends on sfr_pkg, sfr_ctrl, sfr_datapath.
// Each input transfer is loaded while idle, then scanned; results go through the output register.
// Head-byte drops are issued from the scan state; a replacement, flush or bare end mark comes
// from the state that follows scan. A new input transfer is accepted only once the controller
// is back in idle, after all results of the last one are issued; sink stalls hold this up.
// Reset (i_rst_n low, synchronous): empty match buffer, output empty, registers
// pattern 0 / length 1, replacement 0 / length 0.
module stream_find_replace #(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACE_MAX = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [sfr_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [sfr_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // [7:0] in_byte
    input  logic                       s_axis_tuser,   // [0] in_valid
    input  logic                       s_axis_tlast,   // in_end
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata,   // [7:0] out_byte
    output logic                       m_axis_tuser,   // [0] out_valid
    output logic                       m_axis_tlast    // out_last
);
    import sfr_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    sfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_tvalid (s_axis_tvalid),
        .i_in_work   (s_axis_tuser | s_axis_tlast),
        .o_in_tready (s_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sfr_datapath #(
        .PATTERN_MAX (PATTERN_MAX),
        .REPLACE_MAX (REPLACE_MAX)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_byte    (s_axis_tdata),
        .i_in_valid   (s_axis_tuser),
        .i_in_end     (s_axis_tlast),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .o_out_byte   (m_axis_tdata),
        .o_out_valid  (m_axis_tuser),
        .o_out_last   (m_axis_tlast)
    );

endmodule

[design/sfr_datapath.sv]
// Datapath: config registers, partial-match buffer, replacement index, output register.
// Depends on sfr_pkg and stream_find_replace_macros.svh.
`include "stream_find_replace_macros.svh"

module sfr_datapath #(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACE_MAX = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sfr_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [sfr_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [sfr_pkg::BYTE_W-1:0]    i_in_byte,
    input  logic                          i_in_valid,
    input  logic                          i_in_end,
    input  sfr_pkg::t_cmd                 i_cmd,
    output sfr_pkg::t_stat                o_stat,
    output logic                          o_out_tvalid,
    input  logic                          i_out_tready,
    output logic [sfr_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                          o_out_valid,
    output logic                          o_out_last
);
    import sfr_pkg::*;

    localparam int CW = $clog2(PATTERN_MAX + 1);
    localparam int RW = $clog2(REPLACE_MAX + 1);

    logic [CFG_W-1:0]  r_pat_bytes;
    logic [3:0]        r_pat_len;
    logic [CFG_W-1:0]  r_rep_bytes;
    logic [3:0]        r_rep_len;

    logic [BYTE_W-1:0] r_buf [PATTERN_MAX];
    logic [CW-1:0]     r_cnt;
    logic [RW-1:0]     r_ridx;
    logic              r_end;
    logic              r_emitted;

    logic              r_out_tvalid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_valid;
    logic              r_out_last;

    logic [CW-1:0]     plen_eff;
    logic [RW-1:0]     rlen_eff;
    logic [PATTERN_MAX-1:0] ok;
    logic              match;
    logic [BYTE_W-1:0] rep_byte;
    logic [BYTE_W-1:0] n_out_byte;
    logic              out_free;

    always_comb begin
        if (r_pat_len == 4'd0) begin
            plen_eff = CW'(1);
        end else if (r_pat_len > 4'(PATTERN_MAX)) begin
            plen_eff = CW'(PATTERN_MAX);
        end else begin
            plen_eff = CW'(r_pat_len);
        end
        if (r_rep_len > 4'(REPLACE_MAX)) begin
            rlen_eff = RW'(REPLACE_MAX);
        end else begin
            rlen_eff = RW'(r_rep_len);
        end
    end

    // buffer holds a pattern prefix iff every occupied slot matches
    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            ok[i] = (r_cnt <= CW'(i)) || (r_buf[i] == r_pat_bytes[BYTE_W*i +: BYTE_W]);
        end
    end
    assign match = &ok;

    always_comb begin
        rep_byte = '0;
        for (int i = 0; i < REPLACE_MAX; i++) begin
            if (r_ridx == RW'(i)) begin
                rep_byte = r_rep_bytes[BYTE_W*i +: BYTE_W];
            end
        end
    end

    always_comb begin
        case (i_cmd.emit_sel)
            EMIT_BUF: n_out_byte = r_buf[0];
            EMIT_REP: n_out_byte = rep_byte;
            default:  n_out_byte = '0;
        endcase
    end

    assign out_free = !r_out_tvalid || i_out_tready;

    always_comb begin
        o_stat.match     = match;
        o_stat.full      = match && (r_cnt == plen_eff);
        o_stat.cnt_zero  = (r_cnt == '0);
        o_stat.cnt_one   = (r_cnt == CW'(1));
        o_stat.rep_last  = ((RW+1)'(r_ridx) + (RW+1)'(1)) == (RW+1)'(rlen_eff);
        o_stat.rlen_zero = (rlen_eff == '0);
        o_stat.out_free  = out_free;
        o_stat.item_end  = r_end;
        o_stat.emitted   = r_emitted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_bytes  <= '0;
            r_pat_len    <= 4'd1;
            r_rep_bytes  <= '0;
            r_rep_len    <= 4'd0;
            r_cnt        <= '0;
            r_ridx       <= '0;
            r_end        <= 1'b0;
            r_emitted    <= 1'b0;
            r_out_tvalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PAT_BYTES: begin
                        r_pat_bytes <= i_cfg_data;
                        r_cnt       <= '0;
                    end
                    REG_PAT_LEN: begin
                        r_pat_len <= i_cfg_data[3:0];
                        r_cnt     <= '0;
                    end
                    REG_REP_BYTES: r_rep_bytes <= i_cfg_data;
                    REG_REP_LEN:   r_rep_len   <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                if (i_in_valid) begin
                    r_cnt <= r_cnt + CW'(1);
                end
                r_end     <= i_in_end;
                r_emitted <= 1'b0;
                r_ridx    <= '0;
            end
            if (i_cmd.shift) begin
                r_cnt <= r_cnt - CW'(1);
            end
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end
            if (i_cmd.rep_inc) begin
                r_ridx <= r_ridx + RW'(1);
            end
            if (i_cmd.emit_sel != EMIT_NONE) begin
                r_emitted    <= 1'b1;
                r_out_tvalid <= 1'b1;
            end else if (i_out_tready) begin
                r_out_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (i_cmd.load && i_in_valid && (r_cnt == CW'(i))) begin
                r_buf[i] <= i_in_byte;
            end else if (i_cmd.shift) begin
                r_buf[i] <= (i < PATTERN_MAX - 1) ? r_buf[(i + 1) % PATTERN_MAX] : r_buf[i];
            end
        end
        if (i_cmd.emit_sel != EMIT_NONE) begin
            r_out_byte  <= n_out_byte;
            r_out_valid <= (i_cmd.emit_sel != EMIT_MARK);
            r_out_last  <= i_cmd.last;
        end
    end

    assign o_out_tvalid = r_out_tvalid;
    assign o_out_byte   = r_out_byte;
    assign o_out_valid  = r_out_valid;
    assign o_out_last   = r_out_last;

    `SFR_ASSERT_IMP(a_cnt_bound, 1'b1, r_cnt <= plen_eff, "match count above pattern length")
    `SFR_ASSERT_IMP(a_mark_form, r_out_tvalid && !r_out_valid, (r_out_byte == '0) && r_out_last, "bare end mark malformed")

endmodule

[design/sfr_ctrl.sv]
// Controller: sequences load, scan, replacement and flush steps for one transfer.
// Depends on sfr_pkg and stream_find_replace_macros.svh.
`include "stream_find_replace_macros.svh"

module sfr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_tvalid,
    input  logic           i_in_work,
    output logic           o_in_tready,
    input  sfr_pkg::t_stat i_stat,
    output sfr_pkg::t_cmd  o_cmd
);
    import sfr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPL,
        ST_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_comb begin
        n_state       = r_state;
        cmd           = '0;
        cmd.emit_sel  = EMIT_NONE;
        o_in_tready   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_tready = 1'b1;
                if (i_in_tvalid && i_in_work) begin
                    cmd.load = 1'b1;
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!i_stat.match) begin
                    // drop the head byte; the rest is retested next cycle
                    if (i_stat.out_free) begin
                        cmd.emit_sel = EMIT_BUF;
                        cmd.shift    = 1'b1;
                        cmd.last     = i_stat.item_end && i_stat.cnt_one;
                    end
                end else if (i_stat.full) begin
                    cmd.cnt_clr = 1'b1;
                    if (!i_stat.rlen_zero) begin
                        n_state = ST_REPL;
                    end else if (i_stat.item_end) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else if (i_stat.item_end) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_REPL: begin
                if (i_stat.out_free) begin
                    cmd.emit_sel = EMIT_REP;
                    cmd.rep_inc  = 1'b1;
                    cmd.last     = i_stat.item_end && i_stat.rep_last;
                    if (i_stat.rep_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (!i_stat.cnt_zero) begin
                    if (i_stat.out_free) begin
                        cmd.emit_sel = EMIT_BUF;
                        cmd.shift    = 1'b1;
                        cmd.last     = i_stat.cnt_one;
                    end
                end else if (i_stat.emitted) begin
                    n_state = ST_IDLE;
                end else if (i_stat.out_free) begin
                    cmd.emit_sel = EMIT_MARK;
                    cmd.last     = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = cmd;

    `SFR_ASSERT_IMP(a_emit_free, o_cmd.emit_sel != EMIT_NONE, i_stat.out_free, "emit into full output register")
    `SFR_ASSERT_IMP(a_repl_len, r_state == ST_REPL, !i_stat.rlen_zero, "replacement with zero length")
    `SFR_ASSERT_NXT(a_load_scan, o_cmd.load, r_state == ST_SCAN, "load not followed by scan")

endmodule

[verif/stream_find_replace_tb.sv]
// Self-checking testbench for stream_find_replace: directed and random byte streams,
// randomized stalls on both stream ports, results checked against a scoreboard predictor.
// Depends on sfr_pkg and the stream_find_replace RTL.
`timescale 1ns / 100ps

module stream_find_replace_tb;
    import sfr_pkg::*;

    localparam int unsigned DRAIN_CYCLES = 24;
    localparam int unsigned CYCLE_LIMIT  = 500_000;
    localparam int unsigned RANDOM_ITEMS = 500;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } byte_result_t;

    class find_replace_scoreboard;
        logic [63:0]  pat_bytes = '0;
        logic [3:0]   pat_len   = 4'd1;
        logic [63:0]  rep_bytes = '0;
        logic [3:0]   rep_len   = '0;
        logic [7:0]   held[8];
        int unsigned  held_cnt  = 0;
        byte_result_t expected_q[$];
        int unsigned  errors    = 0;

        function void write_reg(logic [IDX_W-1:0] idx, logic [63:0] val);
            case (idx)
                REG_PAT_BYTES: begin
                    pat_bytes = val;
                    held_cnt  = 0;
                end
                REG_PAT_LEN: begin
                    pat_len  = val[3:0];
                    held_cnt = 0;
                end
                REG_REP_BYTES: rep_bytes = val;
                REG_REP_LEN:   rep_len   = val[3:0];
                default: ;
            endcase
        endfunction

        function int unsigned active_len();
            int unsigned plen;
            plen = pat_len;
            if (plen == 0) plen = 1;
            if (plen > 8) plen = 8;
            return plen;
        endfunction

        // Predicts the results caused by one accepted input transfer.
        function void note_transfer(logic [7:0] b, logic valid, logic eos);
            logic [7:0]   seq[9];
            byte_result_t out_q[$];
            byte_result_t tail;
            int unsigned  plen, rlen, n, d, len, i;
            bit           ok, done;
            plen = active_len();
            rlen = (rep_len > 8) ? 8 : rep_len;
            if (held_cnt >= plen) held_cnt = plen - 1;
            if (!valid && !eos) return;
            n = held_cnt;
            for (i = 0; i < n; i++) seq[i] = held[i];
            if (valid) begin
                seq[n] = b;
                n++;
                done = 1'b0;
                for (d = 0; d <= n && !done; d++) begin
                    len = n - d;
                    if (len <= plen) begin
                        ok = 1'b1;
                        for (i = 0; i < len; i++)
                            if (seq[d+i] != pat_bytes[8*i +: 8]) ok = 1'b0;
                        if (ok) begin
                            for (i = 0; i < d; i++)
                                out_q.push_back(byte_result_t'{seq[i], 1'b1, 1'b0});
                            if (len == plen) begin
                                for (i = 0; i < rlen; i++)
                                    out_q.push_back(byte_result_t'{rep_bytes[8*i +: 8],
                                                                   1'b1, 1'b0});
                                held_cnt = 0;
                            end else begin
                                for (i = 0; i < len; i++) held[i] = seq[d+i];
                                held_cnt = len;
                            end
                            done = 1'b1;
                        end
                    end
                end
            end
            if (eos) begin
                for (i = 0; i < held_cnt; i++)
                    out_q.push_back(byte_result_t'{held[i], 1'b1, 1'b0});
                if (out_q.size() == 0) out_q.push_back(byte_result_t'{8'h00, 1'b0, 1'b0});
                tail = out_q.pop_back();
                tail.last = 1'b1;
                out_q.push_back(tail);
                for (i = 0; i < 8; i++) held[i] = 8'h00;
                held_cnt = 0;
            end
            foreach (out_q[j]) expected_q.push_back(out_q[j]);
        endfunction

        function void check_result(byte_result_t got);
            byte_result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected output transfer: data %h valid %b last %b",
                             got.data, got.valid, got.last);
                return;
            end
            want = expected_q.pop_front();
            if (got.data !== want.data || got.valid !== want.valid
                    || got.last !== want.last) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch: expected data %h valid %b last %b, got data %h valid %b last %b",
                             want.data, want.valid, want.last, got.data, got.valid, got.last);
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [IDX_W-1:0]  i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;   // [7:0] in_byte
    logic              s_axis_tuser;   // [0] in_valid
    logic              s_axis_tlast;   // in_end
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [7:0]        m_axis_tdata;   // [7:0] out_byte
    logic              m_axis_tuser;   // [0] out_valid
    logic              m_axis_tlast;   // out_last

    find_replace_scoreboard sb;
    bit                     steady_phase = 1'b0;
    int unsigned            rx_hold      = 0;
    int unsigned            cycle_count  = 0;
    int unsigned            random_sent  = 0;

    stream_find_replace dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady_phase) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    // sink side: random stalls
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(byte_result_t'{m_axis_tdata, m_axis_tuser, m_axis_tlast});
        if (rx_hold != 0) begin
            m_axis_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rx_hold = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic valid, input logic eos);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= valid;
        s_axis_tlast  <= eos;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_transfer(b, valid, eos);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // mask bit i selects register i
    task automatic configure(input logic [3:0] mask, input logic [63:0] pb,
                             input logic [3:0] pl, input logic [63:0] rb,
                             input logic [3:0] rl);
        logic [63:0] vals[4];
        vals[REG_PAT_BYTES] = pb;
        vals[REG_PAT_LEN]   = {60'd0, pl};
        vals[REG_REP_BYTES] = rb;
        vals[REG_REP_LEN]   = {60'd0, rl};
        for (int i = 0; i < 4; i++) begin
            if (mask[i]) begin
                i_cfg_we   <= 1'b1;
                i_cfg_idx  <= IDX_W'(i);
                i_cfg_data <= vals[i];
                @(posedge i_clk);
                sb.write_reg(IDX_W'(i), vals[i]);
            end
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_config(input bit all_regs);
        logic [63:0] pb;
        logic [3:0]  pl, mask;
        pl = ($urandom_range(0, 9) < 6) ? 4'($urandom_range(1, 3)) : 4'($urandom_range(0, 15));
        for (int i = 0; i < 8; i++)
            pb[8*i +: 8] = ($urandom_range(0, 4) != 0) ? 8'(8'h61 + $urandom_range(0, 2))
                                                       : 8'($urandom_range(0, 255));
        mask = all_regs ? 4'hF : 4'($urandom_range(0, 15));
        configure(mask, pb, pl, {$urandom, $urandom}, 4'($urandom_range(0, 15)));
    endtask

    task automatic random_stream();
        logic [7:0]  text[$];
        int unsigned len, plen, r, k, ending;
        plen = sb.active_len();
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 12);
        while (text.size() < len) begin
            r = $urandom_range(0, 9);
            if (r < 3) begin
                for (k = 0; k < plen; k++) text.push_back(sb.pat_bytes[8*k +: 8]);
            end else if (r < 5) begin
                for (k = 0; k < $urandom_range(1, plen); k++)
                    text.push_back(sb.pat_bytes[8*k +: 8]);
            end else if (r < 9) begin
                k = $urandom_range(0, plen - 1);
                text.push_back(sb.pat_bytes[8*k +: 8]);
            end else begin
                text.push_back(8'($urandom_range(0, 255)));
            end
        end
        ending = $urandom_range(0, 9);
        if (len == 0) ending = 8;
        foreach (text[j]) begin
            if ($urandom_range(0, 19) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(text[j], 1'b1, (j == text.size() - 1) && ending < 7);
            random_sent++;
        end
        if (ending == 7 || ending == 8) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            random_sent++;
        end
    endtask

    initial begin
        int unsigned phase;
        sb = new;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: pattern 00, deleted
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        wait_idle();

        // pattern "aab", replacement length saturating to 8
        configure(4'hF, 64'h0000_0000_0062_6161, 4'd3, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b1);
        // partial match dropped by a pattern write, zero length treated as one
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h61, 1'b1, 1'b0);
        wait_idle();
        configure(4'b0010, '0, 4'd0, '0, '0);
        send_item(8'h61, 1'b1, 1'b1);
        wait_idle();

        // full-width pattern of FF, delete on match
        configure(4'hF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h0, 4'd0);
        repeat (7) send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        wait_idle();

        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            steady_phase = (phase % 4 == 1);
            random_config(phase == 0);
            repeat ($urandom_range(3, 8)) random_stream();
            wait_idle();
            phase++;
        end
        steady_phase = 1'b0;

        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
